// ===== hw/rtl/uvs_pkg.sv =====
package uvs_pkg;

  localparam int MAX_DIVISIONS_DEFAULT = 255;
  localparam int ANGLE_BITS_DEFAULT    = 16;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_XW    = 34;
  localparam int CORDIC_ZW    = 33;
  localparam int TRIG_W       = 18;
  localparam int POS_W        = 17;
  localparam int POS_LIMIT    = 65535;

  localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN_START = 34'sd652032874;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // register map, word index
  typedef enum logic [1:0] {
    REG_RADIUS  = 2'd0,
    REG_RINGS   = 2'd1,
    REG_SECTORS = 2'd2
  } uvs_reg_t;

  // per-item data that rides alongside the angle math
  typedef struct packed {
    logic [15:0] radius;
    logic [15:0] corner_a;
    logic [15:0] corner_b;
    logic [15:0] corner_c;
    logic [15:0] corner_d;
    logic        quad_valid;
    logic        side_edge_valid;
    logic        index_error;
  } uvs_side_t;

endpackage

// ===== hw/rtl/uvs_ifs.sv =====
interface uvs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ring_index;
  logic [7:0] sector_index;
  modport source(output valid, ring_index, sector_index, input ready);
  modport sink(input valid, ring_index, sector_index, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] pos_x;
  logic signed [16:0] pos_y;
  logic signed [16:0] pos_z;
  logic [15:0]        corner_a;
  logic [15:0]        corner_b;
  logic [15:0]        corner_c;
  logic [15:0]        corner_d;
  logic               quad_valid;
  logic               side_edge_valid;
  logic               index_error;
  modport source(output valid, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
                 corner_d, quad_valid, side_edge_valid, index_error, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c,
               corner_d, quad_valid, side_edge_valid, index_error, output ready);
endinterface

// ===== hw/rtl/uvs_front.sv =====
module uvs_front #(
  parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          ring_index,
  input  logic [7:0]          sector_index,
  input  logic [15:0]         sphere_radius,
  input  logic [7:0]          ring_count,
  input  logic [7:0]          sector_count,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          num [2],
  output logic [8:0]          den [2],
  output uvs_pkg::uvs_side_t  out_side
);
  import uvs_pkg::*;

  logic        v;
  logic        en;
  logic [7:0]  rings;
  logic [7:0]  sectors;
  logic [8:0]  sp1;
  logic [16:0] a_full;
  logic [15:0] a;
  logic [15:0] b;
  logic        err;
  logic        qv;
  uvs_side_t   side_n;

  assign en       = !v || out_ready;
  assign in_ready = en;

  always_comb begin
    // counts clamped to the supported range
    if (ring_count < 8'd2) begin
      rings = 8'd2;
    end else if (int'(ring_count) > MAX_DIVISIONS) begin
      rings = 8'(MAX_DIVISIONS);
    end else begin
      rings = ring_count;
    end
    if (sector_count < 8'd3) begin
      sectors = 8'd3;
    end else if (int'(sector_count) > MAX_DIVISIONS) begin
      sectors = 8'(MAX_DIVISIONS);
    end else begin
      sectors = sector_count;
    end
    sp1    = {1'b0, sectors} + 9'd1;
    a_full = 17'(ring_index) * 17'(sp1) + 17'(sector_index);
    a      = a_full[15:0];
    b      = a + 16'(sp1);
    err    = (ring_index > rings) || (sector_index > sectors);
    qv     = (ring_index < rings) && (sector_index < sectors);
    side_n.radius          = sphere_radius;
    side_n.corner_a        = err ? 16'd0 : a;
    side_n.corner_b        = err ? 16'd0 : b;
    side_n.corner_c        = err ? 16'd0 : b + 16'd1;
    side_n.corner_d        = err ? 16'd0 : a + 16'd1;
    side_n.quad_valid      = qv && !err;
    side_n.side_edge_valid = qv && !err && (ring_index != 8'd0);
    side_n.index_error     = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num[0]   <= ring_index;
      den[0]   <= {rings, 1'b0};
      num[1]   <= sector_index;
      den[1]   <= {1'b0, sectors};
      out_side <= side_n;
    end
  end

  assign out_valid = v;

endmodule

// ===== hw/rtl/uvs_div.sv =====
module uvs_div #(
  parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          num [2],
  input  logic [8:0]          den [2],
  input  uvs_pkg::uvs_side_t  in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         angle [2],
  output uvs_pkg::uvs_side_t  out_side
);
  import uvs_pkg::*;

  // one quotient bit per stage; for in-range indices the quotient never exceeds one full turn
  localparam int QW  = ANGLE_BITS + 1;
  localparam int NS  = QW;
  localparam int DVW = 9 + ANGLE_BITS;

  logic [NS-1:0] v;
  logic [NS:0]   en;
  logic [8:0]    rem_q [NS][2];
  logic [QW-1:0] low_q [NS][2];
  logic [QW-1:0] quo_q [NS][2];
  logic [8:0]    den_q [NS][2];
  uvs_side_t     side_q [NS];

  logic [8:0]    rem_n [NS][2];
  logic [QW-1:0] low_n [NS][2];
  logic [QW-1:0] quo_n [NS][2];
  logic [8:0]    den_n [NS][2];
  logic [NS-1:0] v_n;
  uvs_side_t     side_n [NS];

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  always_comb begin
    logic [DVW-1:0] dvd;
    logic [8:0]     rem_p;
    logic [QW-1:0]  low_p;
    logic [QW-1:0]  quo_p;
    logic [8:0]     den_p;
    logic [9:0]     trial;
    for (int k = 0; k < NS; k++) begin
      v_n[k]    = (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
      side_n[k] = (k == 0) ? in_side : side_q[(k == 0) ? 0 : k - 1];
      for (int l = 0; l < 2; l++) begin
        dvd = '0;
        if (k == 0) begin
          // dividend is num * 2^ANGLE_BITS + den / 2 for round-half-up
          dvd   = {1'b0, num[l], ANGLE_BITS'(0)} + DVW'(den[l][8:1]);
          rem_p = 9'(dvd[DVW-1:QW]);
          low_p = dvd[QW-1:0];
          quo_p = '0;
          den_p = den[l];
        end else begin
          rem_p = rem_q[k-1][l];
          low_p = low_q[k-1][l];
          quo_p = quo_q[k-1][l];
          den_p = den_q[k-1][l];
        end
        trial = {rem_p, low_p[QW-1]};
        if (trial >= {1'b0, den_p}) begin
          rem_n[k][l] = 9'(trial - {1'b0, den_p});
          quo_n[k][l] = {quo_p[QW-2:0], 1'b1};
        end else begin
          rem_n[k][l] = trial[8:0];
          quo_n[k][l] = {quo_p[QW-2:0], 1'b0};
        end
        low_n[k][l] = {low_p[QW-2:0], 1'b0};
        den_n[k][l] = den_p;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v_n[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        rem_q[k]  <= rem_n[k];
        low_q[k]  <= low_n[k];
        quo_q[k]  <= quo_n[k];
        den_q[k]  <= den_n[k];
        side_q[k] <= side_n[k];
      end
    end
  end

  // quotient taken modulo one turn, placed at the top of a 32-bit turn
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      angle[l] = {quo_q[NS-1][l][ANGLE_BITS-1:0], (32 - ANGLE_BITS)'(0)};
    end
  end
  assign out_side  = side_q[NS-1];
  assign out_valid = v[NS-1];

endmodule

// ===== hw/rtl/uvs_cordic.sv =====
module uvs_cordic (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              angle [2],
  input  uvs_pkg::uvs_side_t       in_side,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [17:0]       cos_val [2],
  output logic signed [17:0]       sin_val [2],
  output uvs_pkg::uvs_side_t       out_side
);
  import uvs_pkg::*;

  // rotation stages, then one stage for rounding and quadrant fold
  localparam int NS = CORDIC_STEPS + 1;

  logic [NS-1:0] v;
  logic [NS:0]   en;
  logic signed [CORDIC_XW-1:0] x_q [CORDIC_STEPS][2];
  logic signed [CORDIC_XW-1:0] y_q [CORDIC_STEPS][2];
  logic signed [CORDIC_ZW-1:0] z_q [CORDIC_STEPS][2];
  logic [1:0]                  quad_q [CORDIC_STEPS][2];
  uvs_side_t                   side_q [NS];

  logic signed [CORDIC_XW-1:0] x_n [CORDIC_STEPS][2];
  logic signed [CORDIC_XW-1:0] y_n [CORDIC_STEPS][2];
  logic signed [CORDIC_ZW-1:0] z_n [CORDIC_STEPS][2];
  logic [1:0]                  quad_n [CORDIC_STEPS][2];
  logic signed [TRIG_W-1:0]    cos_n [2];
  logic signed [TRIG_W-1:0]    sin_n [2];
  logic [NS-1:0]               v_n;
  uvs_side_t                   side_n [NS];

  always_comb begin
    en[NS] = out_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  always_comb begin
    logic signed [CORDIC_XW-1:0] xp;
    logic signed [CORDIC_XW-1:0] yp;
    logic signed [CORDIC_ZW-1:0] zp;
    logic signed [CORDIC_ZW-1:0] at;
    for (int k = 0; k < NS; k++) begin
      v_n[k]    = (k == 0) ? in_valid : v[(k == 0) ? 0 : k - 1];
      side_n[k] = (k == 0) ? in_side : side_q[(k == 0) ? 0 : k - 1];
    end
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      for (int l = 0; l < 2; l++) begin
        if (k == 0) begin
          xp           = CORDIC_GAIN_START;
          yp           = '0;
          zp           = CORDIC_ZW'({2'b00, angle[l][29:0]});
          quad_n[k][l] = angle[l][31:30];
        end else begin
          xp           = x_q[k-1][l];
          yp           = y_q[k-1][l];
          zp           = z_q[k-1][l];
          quad_n[k][l] = quad_q[k-1][l];
        end
        at = $signed({1'b0, ATAN_TURN[k]});
        if (!zp[CORDIC_ZW-1]) begin
          x_n[k][l] = xp - (yp >>> k);
          y_n[k][l] = yp + (xp >>> k);
          z_n[k][l] = zp - at;
        end else begin
          x_n[k][l] = xp + (yp >>> k);
          y_n[k][l] = yp - (xp >>> k);
          z_n[k][l] = zp + at;
        end
      end
    end
  end

  // round to q3.15 (18-bit signed, 15 fraction bits) and fold the quadrant back in
  always_comb begin
    logic signed [CORDIC_XW-1:0] xr;
    logic signed [CORDIC_XW-1:0] yr;
    logic signed [TRIG_W-1:0]    c0;
    logic signed [TRIG_W-1:0]    s0;
    for (int l = 0; l < 2; l++) begin
      xr = (x_q[CORDIC_STEPS-1][l] + 34'sd16384) >>> 15;
      yr = (y_q[CORDIC_STEPS-1][l] + 34'sd16384) >>> 15;
      c0 = TRIG_W'(xr);
      s0 = TRIG_W'(yr);
      unique case (quad_q[CORDIC_STEPS-1][l])
        2'd0: begin
          cos_n[l] = c0;
          sin_n[l] = s0;
        end
        2'd1: begin
          cos_n[l] = -s0;
          sin_n[l] = c0;
        end
        2'd2: begin
          cos_n[l] = -c0;
          sin_n[l] = -s0;
        end
        default: begin
          cos_n[l] = s0;
          sin_n[l] = -c0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) begin
          v[k] <= v_n[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      if (en[k]) begin
        x_q[k]    <= x_n[k];
        y_q[k]    <= y_n[k];
        z_q[k]    <= z_n[k];
        quad_q[k] <= quad_n[k];
      end
    end
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        side_q[k] <= side_n[k];
      end
    end
    if (en[NS-1]) begin
      cos_val <= cos_n;
      sin_val <= sin_n;
    end
  end

  assign out_side  = side_q[NS-1];
  assign out_valid = v[NS-1];

endmodule

// ===== hw/rtl/uvs_scale.sv =====
module uvs_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [17:0]  cos_val [2],
  input  logic signed [17:0]  sin_val [2],
  input  uvs_pkg::uvs_side_t  in_side,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output uvs_pkg::uvs_side_t  out_side
);
  import uvs_pkg::*;

  logic [2:0] v;
  logic [3:0] en;

  // stage 0: radius times alpha terms
  logic signed [34:0] py_q;
  logic signed [34:0] ps_q;
  logic signed [17:0] ct_q;
  logic signed [17:0] st_q;
  uvs_side_t          side0_q;
  // stage 1: second product
  logic signed [51:0] px_q;
  logic signed [51:0] pz_q;
  logic signed [34:0] py1_q;
  uvs_side_t          side1_q;

  logic signed [33:0] ps_n;
  logic signed [51:0] rx;
  logic signed [51:0] rz;
  logic signed [34:0] ry;

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [51:0] val);
    if (val > 52'sd65535) begin
      sat_pos = POS_W'(POS_LIMIT);
    end else if (val < -52'sd65535) begin
      sat_pos = -POS_W'(POS_LIMIT);
    end else begin
      sat_pos = POS_W'(val);
    end
  endfunction

  always_comb begin
    en[3] = out_ready;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end
  assign in_ready = en[0];

  // |radius * sin| stays below 2^31, so 34 bits carry it
  assign ps_n = ps_q[33:0];
  assign rx   = (px_q + 52'sd536870912) >>> 30;
  assign rz   = (pz_q + 52'sd536870912) >>> 30;
  assign ry   = (py1_q + 35'sd16384) >>> 15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      py_q    <= $signed({1'b0, in_side.radius}) * cos_val[0];
      ps_q    <= $signed({1'b0, in_side.radius}) * sin_val[0];
      ct_q    <= cos_val[1];
      st_q    <= sin_val[1];
      side0_q <= in_side;
    end
    if (en[1]) begin
      px_q    <= ps_n * st_q;
      pz_q    <= ps_n * ct_q;
      py1_q   <= py_q;
      side1_q <= side0_q;
    end
    if (en[2]) begin
      if (side1_q.index_error) begin
        pos_x <= '0;
        pos_y <= '0;
        pos_z <= '0;
      end else begin
        pos_x <= sat_pos(rx);
        pos_y <= sat_pos(52'(ry));
        pos_z <= sat_pos(rz);
      end
      out_side <= side1_q;
    end
  end

  assign out_valid = v[2];

endmodule

// ===== hw/rtl/uv_sphere_vertex_generator.sv =====
// channel     dir  handshake       payload
// item_in     in   valid/ready     ring_index, sector_index
// item_out    out  valid/ready     pos_x/y/z, corner_a..d, quad_valid,
//                                  side_edge_valid, index_error
// apb         in   psel/penable    sphere_radius, ring_count, sector_count
//
// one item per cycle sustained while item_out is ready; the pipeline is the
// front stage, the bit-per-stage angle divider, the 24-stage cordic plus a
// rounding stage, and three scale stages
// rst is synchronous and clears every valid bit and the config registers
// each stage loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled output holds without dropping or repeating an item
module uv_sphere_vertex_generator #(
  parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS_DEFAULT,
  parameter int ANGLE_BITS    = uvs_pkg::ANGLE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  uvs_in_if.sink      item_in,
  uvs_out_if.source   item_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import uvs_pkg::*;

  // config registers
  logic [15:0] sphere_radius;
  logic [7:0]  ring_count;
  logic [7:0]  sector_count;
  uvs_reg_t    reg_sel;
  logic        wr_en;

  // front -> divider
  logic        f_valid;
  logic        f_ready;
  logic [7:0]  f_num [2];
  logic [8:0]  f_den [2];
  uvs_side_t   f_side;

  // divider -> cordic, lane 0 is the polar angle, lane 1 the azimuth
  logic        d_valid;
  logic        d_ready;
  logic [31:0] d_angle [2];
  uvs_side_t   d_side;

  // cordic -> scale
  logic               c_valid;
  logic               c_ready;
  logic signed [17:0] c_cos [2];
  logic signed [17:0] c_sin [2];
  uvs_side_t          c_side;

  uvs_side_t          o_side;

  assign pready  = 1'b1;
  assign reg_sel = uvs_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  // writes to an unmapped word are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius <= 16'd256;
      ring_count    <= 8'd2;
      sector_count  <= 8'd3;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RADIUS:  sphere_radius <= pwdata[15:0];
        REG_RINGS:   ring_count    <= pwdata[7:0];
        REG_SECTORS: sector_count  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_RADIUS:  prdata = {16'd0, sphere_radius};
      REG_RINGS:   prdata = {24'd0, ring_count};
      REG_SECTORS: prdata = {24'd0, sector_count};
      default:     prdata = 32'd0;
    endcase
  end

  // clamp counts, corner indices, range flags
  uvs_front #(
    .MAX_DIVISIONS(MAX_DIVISIONS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (item_in.valid),
    .in_ready     (item_in.ready),
    .ring_index   (item_in.ring_index),
    .sector_index (item_in.sector_index),
    .sphere_radius(sphere_radius),
    .ring_count   (ring_count),
    .sector_count (sector_count),
    .out_valid    (f_valid),
    .out_ready    (f_ready),
    .num          (f_num),
    .den          (f_den),
    .out_side     (f_side)
  );

  // index over count (twice the ring count for the polar lane) as a fraction of a turn
  uvs_div #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .num      (f_num),
    .den      (f_den),
    .in_side  (f_side),
    .out_valid(d_valid),
    .out_ready(d_ready),
    .angle    (d_angle),
    .out_side (d_side)
  );

  // sine and cosine of both angles
  uvs_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (d_valid),
    .in_ready (d_ready),
    .angle    (d_angle),
    .in_side  (d_side),
    .out_valid(c_valid),
    .out_ready(c_ready),
    .cos_val  (c_cos),
    .sin_val  (c_sin),
    .out_side (c_side)
  );

  // radius products, rounding, saturation; last stage is the output register
  uvs_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (c_valid),
    .in_ready (c_ready),
    .cos_val  (c_cos),
    .sin_val  (c_sin),
    .in_side  (c_side),
    .out_valid(item_out.valid),
    .out_ready(item_out.ready),
    .pos_x    (item_out.pos_x),
    .pos_y    (item_out.pos_y),
    .pos_z    (item_out.pos_z),
    .out_side (o_side)
  );

  assign item_out.corner_a        = o_side.corner_a;
  assign item_out.corner_b        = o_side.corner_b;
  assign item_out.corner_c        = o_side.corner_c;
  assign item_out.corner_d        = o_side.corner_d;
  assign item_out.quad_valid      = o_side.quad_valid;
  assign item_out.side_edge_valid = o_side.side_edge_valid;
  assign item_out.index_error     = o_side.index_error;

endmodule
